@@ rtl/plcm_pkg.sv @@
// shared constants, codes and types of the piecewise linear color map unit
package plcm_pkg;

  localparam int MAX_KEYS   = 16;
  localparam int LEVEL_BITS = 16;

  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int IDX_W  = $clog2(MAX_KEYS);
  localparam int PROD_W = LEVEL_BITS + 8;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_MAP    = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef logic [LEVEL_BITS-1:0] level_t;

  typedef struct packed {
    level_t      level;
    logic [31:0] left;
    logic [31:0] right;
  } entry_t;

  typedef struct packed {
    logic       start;
    logic [7:0] lo;
    logic [7:0] hi;
    level_t     off;
    level_t     span;
  } blend_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] value;
  } blend_rsp_t;

endpackage

@@ rtl/plcm_in_if.sv @@
// request channel of the color map unit
interface plcm_in_if import plcm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  key_index;
  logic [15:0] key_level;
  logic [31:0] key_left_color;
  logic [31:0] key_right_color;
  logic [15:0] sample_level;

  modport source (
    output valid, action, key_index, key_level, key_left_color, key_right_color,
           sample_level,
    input  ready
  );
  modport sink (
    input  valid, action, key_index, key_level, key_left_color, key_right_color,
           sample_level,
    output ready
  );
endinterface

@@ rtl/plcm_out_if.sv @@
// result channel of the color map unit
interface plcm_out_if import plcm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] color;
  logic [1:0]  status;

  modport source (output valid, color, status, input ready);
  modport sink (input valid, color, status, output ready);
endinterface

@@ rtl/plcm_ram.sv @@
// generic single write port, single read port ram with registered read
module plcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/plcm_blend.sv @@
// one channel interpolation: multiply then restoring divide, one quotient bit a cycle
module plcm_blend import plcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  blend_req_t req_i,
  output blend_rsp_t rsp_o
);
  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_DIV  = 2'd2;
  localparam logic [1:0] B_FIN  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [2:0]        step_q, step_d;
  logic [7:0]        lo_q, lo_d;
  logic              neg_q, neg_d;
  logic [7:0]        mag_q, mag_d;
  level_t            off_q, off_d;
  level_t            span_q, span_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [PROD_W-1:0] dsr_q, dsr_d;
  logic [7:0]        quo_q, quo_d;
  logic              ge;

  assign ge = prod_q >= dsr_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    lo_d    = lo_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    off_d   = off_q;
    span_d  = span_q;
    prod_d  = prod_q;
    dsr_d   = dsr_q;
    quo_d   = quo_q;
    rsp_o.done  = 1'b0;
    rsp_o.value = neg_q ? (lo_q - quo_q) : (lo_q + quo_q);
    case (state_q)
      B_IDLE: begin
        if (req_i.start) begin
          lo_d    = req_i.lo;
          neg_d   = req_i.hi < req_i.lo;
          mag_d   = (req_i.hi < req_i.lo) ? (req_i.lo - req_i.hi) : (req_i.hi - req_i.lo);
          off_d   = req_i.off;
          span_d  = req_i.span;
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        prod_d  = PROD_W'(mag_q) * PROD_W'(off_q);
        // quotient never exceeds the channel difference, so eight bits suffice
        dsr_d   = {1'b0, span_q, 7'b0};
        quo_d   = '0;
        step_d  = '0;
        state_d = B_DIV;
      end
      B_DIV: begin
        if (ge) begin
          prod_d = prod_q - dsr_q;
        end
        quo_d  = {quo_q[6:0], ge};
        dsr_d  = dsr_q >> 1;
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) begin
          state_d = B_FIN;
        end
      end
      B_FIN: begin
        rsp_o.done = 1'b1;
        state_d    = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    off_q  <= off_d;
    span_q <= span_d;
    prod_q <= prod_d;
    dsr_q  <= dsr_d;
    quo_q  <= quo_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (dsr_q[PROD_W-1] == 1'b0))
    else $error("divisor shifted out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> ($past(state_q) == B_DIV && $past(step_q) == 3'd7))
    else $error("blend finished without eight divide steps");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.start && state_q == B_IDLE) |=> (state_q == B_MUL))
    else $error("blend start not taken");
endmodule

@@ rtl/piecewise_linear_color_map_unit.sv @@
// Piecewise linear color map: a sorted table of up to MAX_KEYS color keys held in one
// ram, with insert, remove, clear and map requests handled one at a time by a small
// sequencer. The ram has a registered read, so a scan reads each key in S_SRCH and
// compares the registered data in S_CMP. A clear, a refused insert, a refused remove
// and a map on an empty table go straight to completion. An insert scans for its
// place and moves the keys above it up, a remove moves the keys above it down. A map
// scans the keys and interpolates unless it lands on an end key; for that the
// four byte channels go in turn through one shared multiply and eight-step divider.
// The result waits in an output register, so the next request is taken while it does.
// There is no clearing pass; entries beyond the key count are never read.
module piecewise_linear_color_map_unit import plcm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_we_i,
  input  logic    cfg_wdata_i,
  plcm_in_if.sink    req_i,
  plcm_out_if.source rsp_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_SHRD  = 3'd3;
  localparam logic [2:0] S_SHWR  = 3'd4;
  localparam logic [2:0] S_BLEND = 3'd5;
  localparam logic [2:0] S_BWAIT = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [1:0]       ch_q, ch_d;
  logic             swap_q;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_color_q, out_color_d;
  logic [1:0]       out_status_q, out_status_d;

  logic [1:0]  act_q, act_d;
  level_t      lvl_q, lvl_d;
  level_t      smp_q, smp_d;
  logic [31:0] lcol_q, lcol_d;
  logic [31:0] rcol_q, rcol_d;
  entry_t      prev_q, prev_d;
  entry_t      cur_q, cur_d;
  level_t      off_q, off_d;
  level_t      span_q, span_d;
  logic [31:0] color_q, color_d;
  logic [1:0]  stat_q, stat_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  blend_req_t       blend_req;
  blend_rsp_t       blend_rsp;

  logic [CNT_W-1:0] i_dn, i_up, k_up;
  level_t           key_lvl;
  logic [31:0]      swapped;

  assign i_dn    = i_q - CNT_W'(1);
  assign i_up    = i_q + CNT_W'(1);
  assign k_up    = k_q + CNT_W'(1);
  assign key_lvl = (act_q == ACT_MAP) ? smp_q : lvl_q;
  assign swapped = {color_q[15:8], color_q[23:16], color_q[31:24], color_q[7:0]};

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.color  = out_color_q;
  assign rsp_o.status = out_status_q;

  plcm_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_KEYS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  plcm_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (blend_req),
    .rsp_o  (blend_rsp)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    k_d          = k_q;
    i_d          = i_q;
    ch_d         = ch_q;
    out_valid_d  = out_valid_q;
    out_color_d  = out_color_q;
    out_status_d = out_status_q;
    act_d        = act_q;
    lvl_d        = lvl_q;
    smp_d        = smp_q;
    lcol_d       = lcol_q;
    rcol_d       = rcol_q;
    prev_d       = prev_q;
    cur_d        = cur_q;
    off_d        = off_q;
    span_d       = span_q;
    color_d      = color_q;
    stat_d       = stat_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;
    blend_req.start = 1'b0;
    blend_req.lo    = prev_q.right[{ch_q, 3'b000} +: 8];
    blend_req.hi    = cur_q.left[{ch_q, 3'b000} +: 8];
    blend_req.off   = off_q;
    blend_req.span  = span_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          act_d   = req_i.action;
          lvl_d   = LEVEL_BITS'(req_i.key_level);
          smp_d   = LEVEL_BITS'(req_i.sample_level);
          lcol_d  = req_i.key_left_color;
          rcol_d  = req_i.key_right_color;
          color_d = '0;
          stat_d  = STATUS_OK;
          k_d     = '0;
          case (req_i.action)
            ACT_CLEAR: begin
              cnt_d   = '0;
              state_d = S_DONE;
            end
            ACT_INSERT: begin
              if (cnt_q == CNT_W'(MAX_KEYS)) begin
                stat_d  = STATUS_FULL;
                state_d = S_DONE;
              end else begin
                state_d = S_SRCH;
              end
            end
            ACT_REMOVE: begin
              if (32'(req_i.key_index) >= 32'(cnt_q)) begin
                stat_d  = STATUS_RANGE;
                state_d = S_DONE;
              end else begin
                i_d     = CNT_W'(req_i.key_index);
                state_d = S_SHRD;
              end
            end
            ACT_MAP: begin
              state_d = (cnt_q == '0) ? S_DONE : S_SRCH;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SRCH: begin
        if (k_q == cnt_q) begin
          // ran past the last key
          if (act_q == ACT_INSERT) begin
            i_d     = cnt_q;
            state_d = S_SHRD;
          end else begin
            color_d = prev_q.right;
            state_d = S_DONE;
          end
        end else begin
          ram_raddr = k_q[IDX_W-1:0];
          state_d   = S_CMP;
        end
      end
      S_CMP: begin
        if (key_lvl > ram_rdata.level) begin
          prev_d  = ram_rdata;
          k_d     = k_up;
          state_d = S_SRCH;
        end else begin
          cur_d = ram_rdata;
          if (act_q == ACT_INSERT) begin
            i_d     = cnt_q;
            state_d = S_SHRD;
          end else if (k_q == '0) begin
            color_d = ram_rdata.left;
            state_d = S_DONE;
          end else begin
            off_d   = smp_q - prev_q.level;
            span_d  = ram_rdata.level - prev_q.level;
            ch_d    = '0;
            state_d = S_BLEND;
          end
        end
      end
      S_SHRD: begin
        if (act_q == ACT_INSERT) begin
          if (i_q == k_q) begin
            ram_we    = 1'b1;
            ram_waddr = k_q[IDX_W-1:0];
            ram_wdata = '{level: lvl_q, left: lcol_q, right: rcol_q};
            cnt_d     = cnt_q + CNT_W'(1);
            state_d   = S_DONE;
          end else begin
            ram_raddr = i_dn[IDX_W-1:0];
            state_d   = S_SHWR;
          end
        end else begin
          if (i_up == cnt_q) begin
            cnt_d   = cnt_q - CNT_W'(1);
            state_d = S_DONE;
          end else begin
            ram_raddr = i_up[IDX_W-1:0];
            state_d   = S_SHWR;
          end
        end
      end
      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = i_q[IDX_W-1:0];
        ram_wdata = ram_rdata;
        i_d       = (act_q == ACT_INSERT) ? i_dn : i_up;
        state_d   = S_SHRD;
      end
      S_BLEND: begin
        blend_req.start = 1'b1;
        state_d         = S_BWAIT;
      end
      S_BWAIT: begin
        if (blend_rsp.done) begin
          color_d[{ch_q, 3'b000} +: 8] = blend_rsp.value;
          ch_d    = ch_q + 2'd1;
          state_d = (ch_q == 2'd3) ? S_DONE : S_BLEND;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_color_d  = (act_q == ACT_MAP && swap_q) ? swapped : color_q;
          out_status_d = stat_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      i_q         <= '0;
      ch_q        <= '0;
      swap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      i_q         <= i_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        swap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_color_q  <= out_color_d;
    out_status_q <= out_status_d;
    act_q        <= act_d;
    lvl_q        <= lvl_d;
    smp_q        <= smp_d;
    lcol_q       <= lcol_d;
    rcol_q       <= rcol_d;
    prev_q       <= prev_d;
    cur_q        <= cur_d;
    off_q        <= off_d;
    span_q       <= span_d;
    color_q      <= color_d;
    stat_q       <= stat_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_KEYS))
    else $error("key count beyond table depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != S_IDLE))
    else $error("accepted request not processed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result loaded outside completion");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BLEND) |-> (span_q != '0 && off_q <= span_q))
    else $error("interpolation with bad span");
endmodule
